>>> rtl/ndpf_pkg.sv
// shared types and constants of the near-duplicate point filter
`timescale 1ns / 1ps

package ndpf_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int SEEN_W     = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;

    localparam logic [CFG_IDX_W-1:0]  REG_TOLERANCE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_SKIP_COUNT = 8'd1;

    localparam logic [CFG_DATA_W-1:0] TOLERANCE_RST  = 16'd64;
    localparam logic [CFG_DATA_W-1:0] SKIP_COUNT_RST = 16'd0;
    localparam logic [SQ_W-1:0]       LIMIT_SQ_RST   = 32'd4096;
    localparam logic [SEEN_W-1:0]     SEEN_MAX       = 16'hffff;

    typedef enum logic [1:0] {
        V_KEPT = 2'd0,
        V_DUP  = 2'd1,
        V_SKIP = 2'd2,
        V_FULL = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic issue;
        logic write;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_dp_status;

endpackage

>>> rtl/ndpf_if.sv
// stream and configuration channel interfaces of the near-duplicate point filter
`timescale 1ns / 1ps

interface ndpf_point_if #(
    parameter int COORD_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic                          first_of_list;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;

    modport source (output valid, first_of_list, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, first_of_list, pos_x, pos_y, pos_z, output ready);
endinterface

interface ndpf_result_if import ndpf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_verdict verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

interface ndpf_cfg_if import ndpf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ndpf_dp.sv
// datapath: kept point table, point register and pipelined distance unit
`timescale 1ns / 1ps

module ndpf_dp import ndpf_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_WIDTH = 24,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tol_we,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  t_dp_cmd                       i_cmd,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    output t_dp_status                    o_status
);

    localparam int WORD_W = 3 * COORD_WIDTH;
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int EXT_W  = (DIFF_W > MAG_W + 1) ? DIFF_W : MAG_W + 1;

    logic [WORD_W-1:0]             r_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]             r_rd;
    logic signed [COORD_WIDTH-1:0] r_pt [3];
    logic [SQ_W-1:0]               r_limit_sq;
    logic                          r_v1, r_v2, r_v3;
    logic [MAG_W-1:0]              r_mag [3];
    logic                          r_far2;
    logic [SQ_W-1:0]               r_sq [3];
    logic                          r_far3;
    logic                          r_hit;

    logic signed [DIFF_W-1:0]      diff [3];
    logic [DIFF_W-1:0]             mag [3];
    logic [EXT_W-1:0]              mag_ext [3];
    logic                          far;
    logic [SUM_W-1:0]              sum;

    // point register and distance limit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt[0] <= i_pos_x;
            r_pt[1] <= i_pos_y;
            r_pt[2] <= i_pos_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_sq <= LIMIT_SQ_RST;
        end else if (i_tol_we) begin
            r_limit_sq <= SQ_W'(i_cfg_data) * SQ_W'(i_cfg_data);
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[i_wr_addr] <= {r_pt[0], r_pt[1], r_pt[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // coordinate differences and magnitudes
    always_comb begin
        far = 1'b0;
        for (int k = 0; k < 3; k++) begin
            diff[k]    = {r_pt[k][COORD_WIDTH-1], r_pt[k]}
                       - {r_rd[(3-k)*COORD_WIDTH-1], r_rd[(3-k)*COORD_WIDTH-1 -: COORD_WIDTH]};
            mag[k]     = diff[k][DIFF_W-1] ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);
            mag_ext[k] = EXT_W'(mag[k]);
            far        = far | (mag_ext[k] > EXT_W'(SEEN_MAX));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_mag[k] <= mag_ext[k][MAG_W-1:0];
            r_sq[k]  <= SQ_W'(r_mag[k]) * SQ_W'(r_mag[k]);
        end
        r_far2 <= far;
        r_far3 <= r_far2;
    end

    assign sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_v3 && !r_far3 && (sum < SUM_W'(r_limit_sq))) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_status.busy = r_v1 | r_v2 | r_v3;
    assign o_status.hit  = r_hit;

endmodule

>>> rtl/ndpf_ctrl.sv
// controller: list counters, table scan sequencing and result register
`timescale 1ns / 1ps

module ndpf_ctrl import ndpf_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_skip_we,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pt_valid,
    input  logic                  i_pt_first,
    output logic                  o_pt_ready,
    output logic                  o_res_valid,
    output t_verdict              o_res_verdict,
    input  logic                  i_res_ready,
    output t_dp_cmd               o_cmd,
    output logic [ADDR_W-1:0]     o_rd_addr,
    output logic [ADDR_W-1:0]     o_wr_addr,
    input  t_dp_status            i_status
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_kept_count, n_kept_count;
    logic [SEEN_W-1:0]     r_items_seen, n_items_seen;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    t_verdict              r_verdict, n_verdict;
    logic                  r_out_valid, n_out_valid;
    t_verdict              r_out_verdict, n_out_verdict;
    logic [CFG_DATA_W-1:0] r_skip_count;

    logic [SEEN_W-1:0]     seen;
    logic [CNT_W-1:0]      count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_kept_count <= '0;
            r_items_seen <= '0;
            r_out_valid  <= 1'b0;
            r_skip_count <= SKIP_COUNT_RST;
        end else begin
            r_state      <= n_state;
            r_kept_count <= n_kept_count;
            r_items_seen <= n_items_seen;
            r_out_valid  <= n_out_valid;
            if (i_skip_we) begin
                r_skip_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
    end

    always_comb begin
        n_state       = r_state;
        n_kept_count  = r_kept_count;
        n_items_seen  = r_items_seen;
        n_idx         = r_idx;
        n_verdict     = r_verdict;
        n_out_valid   = r_out_valid & ~i_res_ready;
        n_out_verdict = r_out_verdict;
        o_cmd         = '0;
        o_pt_ready    = 1'b0;
        seen          = i_pt_first ? '0 : r_items_seen;
        count         = i_pt_first ? '0 : r_kept_count;

        unique case (r_state)
            S_IDLE: begin
                o_pt_ready = 1'b1;
                if (i_pt_valid) begin
                    o_cmd.load   = 1'b1;
                    n_kept_count = count;
                    n_items_seen = (seen == SEEN_MAX) ? seen : seen + 1'b1;
                    n_idx        = '0;
                    if (seen < r_skip_count) begin
                        n_verdict = V_SKIP;
                        n_state   = S_DONE;
                    end else if (count == '0) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (CNT_W'(r_idx) == r_kept_count - 1'b1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = S_DONE;
                    if (i_status.hit) begin
                        n_verdict = V_DUP;
                    end else if (r_kept_count < CNT_W'(TABLE_DEPTH)) begin
                        n_verdict    = V_KEPT;
                        o_cmd.write  = 1'b1;
                        n_kept_count = r_kept_count + 1'b1;
                    end else begin
                        n_verdict = V_FULL;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr     = r_idx;
    assign o_wr_addr     = r_kept_count[ADDR_W-1:0];
    assign o_res_valid   = r_out_valid;
    assign o_res_verdict = r_out_verdict;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_count <= CNT_W'(TABLE_DEPTH))
        else $error("kept count beyond table depth");

    a_issue_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (CNT_W'(r_idx) < r_kept_count))
        else $error("read of an entry that was never stored");

    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> (!i_status.hit && !i_status.busy
                         && r_kept_count < CNT_W'(TABLE_DEPTH)))
        else $error("store of a duplicate or into a full table");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && !o_cmd.write) |=> $stable(r_kept_count))
        else $error("kept count moved without a store");

endmodule

>>> rtl/near_duplicate_point_filter.sv
// top level of the near-duplicate point filter
`timescale 1ns / 1ps

// Each point transfer yields one verdict transfer. A point is checked against
// the kept table by one distance unit that reads one stored point a cycle from
// the table memory's read port, and the filter is not ready for the next point
// until the current point's verdict has been handed to the output register. The
// verdict sits in an output register, so the next point is taken while it
// waits. Configuration writes are always ready and must be made while the
// filter is idle; an index other than 0 (tolerance) or 1 (skip_count) is
// ignored.

module near_duplicate_point_filter import ndpf_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_WIDTH = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ndpf_cfg_if.sink       i_cfg,
    ndpf_point_if.sink     i_point,
    ndpf_result_if.source  o_result
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic              cfg_wr;
    logic              tol_we;
    logic              skip_we;
    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;
    assign tol_we      = cfg_wr & (i_cfg.index == REG_TOLERANCE);
    assign skip_we     = cfg_wr & (i_cfg.index == REG_SKIP_COUNT);

    ndpf_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_skip_we     (skip_we),
        .i_cfg_data    (i_cfg.data),
        .i_pt_valid    (i_point.valid),
        .i_pt_first    (i_point.first_of_list),
        .o_pt_ready    (i_point.ready),
        .o_res_valid   (o_result.valid),
        .o_res_verdict (o_result.verdict),
        .i_res_ready   (o_result.ready),
        .o_cmd         (cmd),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .i_status      (status)
    );

    ndpf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tol_we   (tol_we),
        .i_cfg_data (i_cfg.data),
        .i_cmd      (cmd),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_pos_x    (i_point.pos_x),
        .i_pos_y    (i_point.pos_y),
        .i_pos_z    (i_point.pos_z),
        .o_status   (status)
    );

endmodule

>>> verif/tb_near_duplicate_point_filter.sv
// self-checking testbench for the near-duplicate point filter
`timescale 1ns / 1ps

module tb_near_duplicate_point_filter import ndpf_pkg::*;;

    localparam int TABLE_DEPTH = 256;
    localparam int COORD_W     = 24;
    localparam int MAX_MAG     = 65535;

    typedef struct {
        logic                      first;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ndpf_point_if #(.COORD_WIDTH(COORD_W)) pt ();
    ndpf_result_if res ();
    ndpf_cfg_if cfg ();

    near_duplicate_point_filter #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .COORD_WIDTH(COORD_W)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_point  (pt),
        .o_result (res)
    );

    always #1 i_clk = ~i_clk;

    t_point   pending_points[$];
    t_verdict expected_verdicts[$];
    int       error_count = 0;

    // own copy of the filter state
    logic signed [COORD_W-1:0] kept_x[TABLE_DEPTH];
    logic signed [COORD_W-1:0] kept_y[TABLE_DEPTH];
    logic signed [COORD_W-1:0] kept_z[TABLE_DEPTH];
    int                        kept_n = 0;
    int                        seen_n = 0;
    logic [CFG_DATA_W-1:0]     tol_reg  = TOLERANCE_RST;
    logic [CFG_DATA_W-1:0]     skip_reg = SKIP_COUNT_RST;

    function automatic bit near_kept(t_point p, int i);
        longint d[3];
        longint sum;
        sum  = 0;
        d[0] = longint'(p.x) - longint'(kept_x[i]);
        d[1] = longint'(p.y) - longint'(kept_y[i]);
        d[2] = longint'(p.z) - longint'(kept_z[i]);
        for (int k = 0; k < 3; k++) begin
            if (d[k] < 0)
                d[k] = -d[k];
            if (d[k] > MAX_MAG)
                return 1'b0;
            sum += d[k] * d[k];
        end
        return sum < longint'(tol_reg) * longint'(tol_reg);
    endfunction

    function automatic t_verdict filter_point(t_point p);
        int seen_now;
        if (p.first) begin
            kept_n = 0;
            seen_n = 0;
        end
        seen_now = seen_n;
        if (seen_n < 65535)
            seen_n++;
        if (seen_now < int'(skip_reg))
            return V_SKIP;
        for (int i = 0; i < kept_n; i++) begin
            if (near_kept(p, i))
                return V_DUP;
        end
        if (kept_n < TABLE_DEPTH) begin
            kept_x[kept_n] = p.x;
            kept_y[kept_n] = p.y;
            kept_z[kept_n] = p.z;
            kept_n++;
            return V_KEPT;
        end
        return V_FULL;
    endfunction

    // point driver: bursts with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_point nxt;
        if (!i_rst_n) begin
            pt.valid <= 1'b0;
        end else if (!pt.valid || pt.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                pt.valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                nxt = pending_points.pop_front();
                pt.valid         <= 1'b1;
                pt.first_of_list <= nxt.first;
                pt.pos_x         <= nxt.x;
                pt.pos_y         <= nxt.y;
                pt.pos_z         <= nxt.z;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end else begin
                pt.valid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern plus one long hold-off
    int rx_count       = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    int pattern_left   = 0;
    int stall_pct      = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready)
                rx_count++;
            if (!long_hold_done && rx_count == 30) begin
                hold_left      = 600;
                long_hold_done = 1'b1;
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end else begin
                pattern_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // monitor: register writes, point transfers and verdict checks
    always @(posedge i_clk) begin
        t_verdict want;
        t_point   got;
        if (i_rst_n) begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_TOLERANCE)
                    tol_reg = cfg.data;
                else if (cfg.index == REG_SKIP_COUNT)
                    skip_reg = cfg.data;
            end
            if (res.valid && res.ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("verdict %0d with no expected verdict pending", res.verdict);
                    error_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (res.verdict !== want) begin
                        $error("verdict: expected %0d (%s), got %0d", want, want.name(),
                               res.verdict);
                        error_count++;
                    end
                end
            end
            if (pt.valid && pt.ready) begin
                got.first = pt.first_of_list;
                got.x     = pt.pos_x;
                got.y     = pt.pos_y;
                got.z     = pt.pos_z;
                expected_verdicts.push_back(filter_point(got));
            end
        end
    end

    task automatic push_point(input logic first, input int x, input int y, input int z);
        t_point p;
        p.first = first;
        p.x     = COORD_W'(x);
        p.y     = COORD_W'(y);
        p.z     = COORD_W'(z);
        pending_points.push_back(p);
    endtask

    // checked at the falling edge so that the driver and monitor have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_points.size() != 0 || pt.valid || expected_verdicts.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int rand_coord();
        return int'($signed(COORD_W'($urandom)));
    endfunction

    function automatic int rand_off(int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // a list built around a few nearby centres, with some stray points
    task automatic random_list(input int len, input int spread);
        int  ctr[3][3];
        int  v[3];
        int  c;
        logic first;
        for (int k = 0; k < 3; k++)
            ctr[0][k] = rand_coord();
        for (int j = 1; j < 3; j++)
            for (int k = 0; k < 3; k++)
                ctr[j][k] = ctr[0][k] + rand_off(3 * spread);
        for (int i = 0; i < len; i++) begin
            first = (i == 0) || ($urandom_range(0, 40) == 0);
            if ($urandom_range(0, 7) == 0) begin
                for (int k = 0; k < 3; k++)
                    v[k] = rand_coord();
            end else begin
                c = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++)
                    v[k] = ctr[c][k] + rand_off(spread);
            end
            push_point(first, v[0], v[1], v[2]);
        end
    endtask

    task automatic random_phase();
        logic [CFG_DATA_W-1:0] tol;
        logic [CFG_DATA_W-1:0] skip;
        int                    n_lists;
        case ($urandom_range(0, 5))
            0: tol = 16'($urandom);
            1: tol = 16'd0;
            2: tol = 16'hffff;
            3: tol = 16'($urandom_range(1000, 20000));
            default: tol = 16'($urandom_range(1, 300));
        endcase
        case ($urandom_range(0, 7))
            5: skip = 16'd0;
            6: skip = 16'($urandom_range(4, 20));
            7: skip = 16'hffff;
            default: skip = 16'($urandom_range(0, 3));
        endcase
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_SKIP_COUNT, skip);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(2, 255)), 16'($urandom));
        n_lists = $urandom_range(3, 6);
        for (int l = 0; l < n_lists; l++) begin
            random_list($urandom_range(1, 16), 2 * int'(tol) + 2);
            if ($urandom_range(0, 5) == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    // one long list that runs the kept table past full
    task automatic fill_table();
        logic [CFG_DATA_W-1:0] tol;
        int                    fx[$];
        int                    fy[$];
        int                    fz[$];
        int                    j;
        int                    half;
        tol  = 16'($urandom_range(0, 64));
        half = int'(tol) / 2;
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_SKIP_COUNT, 16'($urandom_range(0, 2)));
        while (fx.size() < TABLE_DEPTH + 8) begin
            if (fx.size() > 0 && $urandom_range(0, 5) == 0) begin
                j = $urandom_range(0, fx.size() - 1);
                push_point(1'b0, fx[j] + $urandom_range(0, half),
                           fy[j] - $urandom_range(0, half), fz[j] + $urandom_range(0, half));
            end else begin
                fx.push_back(fx.size() * 256 - 40000);
                fy.push_back(rand_coord());
                fz.push_back(rand_coord());
                push_point(fx.size() == 1, fx[$], fy[$], fz[$]);
            end
        end
        push_point(1'b1, rand_coord(), rand_coord(), rand_coord());
        wait_idle();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        pt.valid         = 1'b0;
        pt.first_of_list = 1'b0;
        pt.pos_x         = '0;
        pt.pos_y         = '0;
        pt.pos_z         = '0;
        res.ready        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, no list start yet
        push_point(1'b0, 0, 0, 0);
        push_point(1'b0, 63, 0, 0);
        push_point(1'b0, 64, 0, 0);
        push_point(1'b0, 8388607, 8388607, 8388607);
        push_point(1'b0, -8388608, -8388608, -8388608);
        push_point(1'b0, 8388597, 8388607, 8388607);
        push_point(1'b1, 63, 0, 0);
        push_point(1'b0, 0, 0, 0);
        wait_idle();

        // writes to unused indexes are dropped
        write_reg(8'd2, 16'd1);
        write_reg(8'hff, 16'hffff);
        write_reg(REG_TOLERANCE, 16'hffff);
        write_reg(REG_SKIP_COUNT, 16'd3);
        push_point(1'b1, 0, 0, 0);
        push_point(1'b0, 0, 0, 0);
        push_point(1'b0, 5, 5, 5);
        push_point(1'b0, 0, 0, 0);
        push_point(1'b0, 65534, 0, 0);
        push_point(1'b0, 65535, 0, 0);
        push_point(1'b0, -65536, 0, 0);
        push_point(1'b0, 37838, 37838, -37838);
        wait_idle();

        write_reg(REG_TOLERANCE, 16'd0);
        write_reg(REG_SKIP_COUNT, 16'hffff);
        push_point(1'b1, 1, 2, 3);
        push_point(1'b0, 1, 2, 3);
        wait_idle();
        write_reg(REG_SKIP_COUNT, 16'd0);
        push_point(1'b1, 1, 2, 3);
        push_point(1'b0, 1, 2, 3);
        wait_idle();

        for (int p = 0; p < 3; p++)
            random_phase();
        fill_table();
        for (int p = 0; p < 3; p++)
            random_phase();

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_near_duplicate_point_filter passed");
        end else begin
            $display("tb_near_duplicate_point_filter failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_near_duplicate_point_filter failed");
        $finish;
    end

endmodule
